@@ hw/rtl/i2c_bit_level_master_defines.svh @@
// ----------------------------------------------------------------------------
// I2C bit engine assertion macros
// Shared helpers for the concurrent checks of the I2C bit engine.
// ----------------------------------------------------------------------------
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine package
// Word types, command classes, phase codes and register indexes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 4'd1;

    localparam logic [7:0] HALF_PERIOD_RST = 8'd2;
    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_SEND  = 3'd2;
    localparam logic [2:0] OP_WAIT  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] opcode;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_failed;
    } t_out_word;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_STOP,
        CMD_SEND,
        CMD_WAIT,
        CMD_READ
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } t_tick;

    typedef struct packed {
        logic [7:0] half_period;
        logic [7:0] ack_timeout;
    } t_cfg;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_SP_C,
        PH_TX_SET,
        PH_TX_HI,
        PH_TX_LO,
        PH_WA_A,
        PH_WA_B,
        PH_WA_POLL,
        PH_RD_LO,
        PH_RD_HI,
        PH_RD_ACKLO,
        PH_RD_ACKHI
    } t_phase;

endpackage

@@ hw/rtl/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine front end
// Accepts tick words, classifies the command and holds them in a
// two-entry queue for the engine.
// ----------------------------------------------------------------------------
module i2cm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  i2cm_pkg::t_in_word i_in_word,
    input  logic              i_pop,
    output logic              o_tick_valid,
    output i2cm_pkg::t_tick   o_tick
);
    import i2cm_pkg::*;

    t_tick      r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;
    t_tick      w_class;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_class          = '0;
        w_class.tx_byte  = i_in_word.tx_byte;
        w_class.send_ack = i_in_word.send_ack;
        w_class.sda_in   = i_in_word.sda_in;
        w_class.cmd      = CMD_NONE;
        if (i_in_word.cmd_valid) begin
            unique case (i_in_word.opcode)
                OP_START: w_class.cmd = CMD_START;
                OP_STOP:  w_class.cmd = CMD_STOP;
                OP_SEND:  w_class.cmd = CMD_SEND;
                OP_WAIT:  w_class.cmd = CMD_WAIT;
                OP_READ:  w_class.cmd = CMD_READ;
                default:  w_class.cmd = CMD_NONE;
            endcase
        end
    end

    assign o_in_ready   = (r_count != 2'd2);
    assign o_tick_valid = (r_count != 2'd0);
    assign o_tick       = r_mem[r_rd_ptr];
    assign w_push       = i_in_valid && o_in_ready;
    assign w_pop        = i_pop && o_tick_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (!w_push && w_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_class;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

endmodule

@@ hw/rtl/i2cm_engine.sv @@
// ----------------------------------------------------------------------------
// I2C bit engine sequencer
// Runs the pin phase sequences one tick word per cycle while the output register
// is free or being emptied, and registers the resulting pin and status word.
// ----------------------------------------------------------------------------
module i2cm_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2cm_pkg::t_cfg     i_cfg,
    input  logic               i_tick_valid,
    input  i2cm_pkg::t_tick    i_tick,
    output logic               o_tick_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output i2cm_pkg::t_out_word o_out_word
);
    import i2cm_pkg::*;

    t_phase     r_phase;
    t_phase     n_phase;
    logic [3:0] r_bit_count;
    logic [3:0] n_bit_count;
    logic [7:0] r_shift;
    logic [7:0] n_shift;
    logic [7:0] r_tick;
    logic [7:0] n_tick;
    logic [7:0] r_poll;
    logic [7:0] n_poll;
    logic       r_ack_choice;
    logic       n_ack_choice;
    logic       r_scl;
    logic       n_scl;
    logic       r_sda;
    logic       n_sda;
    logic       r_drv;
    logic       n_drv;
    logic       r_fail;
    logic       n_fail;
    logic [7:0] r_rx;
    logic [7:0] n_rx;
    logic       r_out_valid;
    t_out_word  r_out_word;
    t_out_word  w_word;

    logic       w_go;
    logic [7:0] w_long;
    logic [8:0] w_short_sum;
    logic [7:0] w_short;
    logic [7:0] w_long_m1;
    logic [7:0] w_short_m1;
    logic [3:0] w_bc_inc;
    logic       w_poll_low;
    logic       w_poll_fail;
    logic       w_waiting;

    assign w_go        = i_tick_valid && (!r_out_valid || i_out_ready);
    assign o_tick_pop  = w_go;
    assign w_long      = (i_cfg.half_period == 8'd0) ? 8'd1 : i_cfg.half_period;
    assign w_short_sum = {1'b0, w_long} + 9'd1;
    assign w_short     = w_short_sum[8:1];
    assign w_long_m1   = w_long - 8'd1;
    assign w_short_m1  = w_short - 8'd1;
    assign w_bc_inc    = r_bit_count + 4'd1;
    assign w_poll_low  = !i_tick.sda_in;
    assign w_poll_fail = (r_poll >= i_cfg.ack_timeout);
    assign w_waiting   = (r_tick != 8'd0);

    // Next phase.
    always_comb begin
        n_phase = r_phase;
        if (w_go) begin
            unique case (r_phase)
                PH_IDLE: begin
                    unique case (i_tick.cmd)
                        CMD_START: n_phase = PH_ST_A;
                        CMD_STOP:  n_phase = PH_SP_A;
                        CMD_SEND:  n_phase = PH_TX_SET;
                        CMD_WAIT:  n_phase = PH_WA_A;
                        CMD_READ:  n_phase = PH_RD_LO;
                        default:   n_phase = PH_IDLE;
                    endcase
                end
                PH_WA_POLL: begin
                    if (w_poll_low) begin
                        n_phase = PH_IDLE;
                    end else if (w_poll_fail) begin
                        n_phase = PH_SP_A;
                    end
                end
                default: begin
                    if (!w_waiting) begin
                        unique case (r_phase)
                            PH_ST_A:     n_phase = PH_ST_B;
                            PH_ST_B:     n_phase = PH_IDLE;
                            PH_SP_A:     n_phase = PH_SP_B;
                            PH_SP_B:     n_phase = PH_SP_C;
                            PH_SP_C:     n_phase = PH_IDLE;
                            PH_TX_SET:   n_phase = PH_TX_HI;
                            PH_TX_HI:    n_phase = PH_TX_LO;
                            PH_TX_LO:    n_phase = w_bc_inc[3] ? PH_IDLE : PH_TX_SET;
                            PH_WA_A:     n_phase = PH_WA_B;
                            PH_WA_B: begin
                                if (w_poll_low) begin
                                    n_phase = PH_IDLE;
                                end else if (w_poll_fail) begin
                                    n_phase = PH_SP_A;
                                end else begin
                                    n_phase = PH_WA_POLL;
                                end
                            end
                            PH_RD_LO:    n_phase = PH_RD_HI;
                            PH_RD_HI:    n_phase = w_bc_inc[3] ? PH_RD_ACKLO : PH_RD_LO;
                            PH_RD_ACKLO: n_phase = PH_RD_ACKHI;
                            PH_RD_ACKHI: n_phase = PH_IDLE;
                            default:     n_phase = PH_IDLE;
                        endcase
                    end
                end
            endcase
        end
    end

    // Datapath and pin updates.
    always_comb begin
        n_bit_count  = r_bit_count;
        n_shift      = r_shift;
        n_tick       = r_tick;
        n_poll       = r_poll;
        n_ack_choice = r_ack_choice;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_drv        = r_drv;
        n_fail       = r_fail;
        n_rx         = r_rx;
        if (w_go) begin
            unique case (r_phase)
                PH_IDLE: begin
                    unique case (i_tick.cmd)
                        CMD_START: begin
                            {n_scl, n_sda, n_drv} = 3'b111;
                            n_tick = w_long_m1;
                        end
                        CMD_STOP: begin
                            {n_scl, n_sda, n_drv} = 3'b001;
                            n_tick = 8'd0;
                        end
                        CMD_SEND: begin
                            n_shift     = i_tick.tx_byte;
                            n_bit_count = 4'd0;
                            n_scl       = 1'b0;
                            n_sda       = i_tick.tx_byte[7];
                            n_drv       = 1'b1;
                            n_tick      = 8'd0;
                        end
                        CMD_WAIT: begin
                            n_fail = 1'b0;
                            n_poll = 8'd0;
                            n_sda  = 1'b1;
                            n_drv  = 1'b0;
                            n_tick = w_short_m1;
                        end
                        CMD_READ: begin
                            n_ack_choice = i_tick.send_ack;
                            n_shift      = 8'd0;
                            n_bit_count  = 4'd0;
                            {n_scl, n_sda, n_drv} = 3'b010;
                            n_tick = w_long_m1;
                        end
                        default: begin
                            n_tick = r_tick;
                        end
                    endcase
                end
                PH_WA_POLL, PH_WA_B: begin
                    if (r_phase == PH_WA_POLL || !w_waiting) begin
                        n_tick = 8'd0;
                        if (w_poll_low) begin
                            {n_scl, n_sda, n_drv} = 3'b010;
                        end else if (w_poll_fail) begin
                            n_fail = 1'b1;
                            {n_scl, n_sda, n_drv} = 3'b001;
                        end else begin
                            n_poll = r_poll + 8'd1;
                        end
                    end else begin
                        n_tick = r_tick - 8'd1;
                    end
                end
                default: begin
                    if (w_waiting) begin
                        n_tick = r_tick - 8'd1;
                    end else begin
                        n_tick = w_long_m1;
                        unique case (r_phase)
                            PH_ST_A: {n_scl, n_sda, n_drv} = 3'b101;
                            PH_ST_B: begin
                                {n_scl, n_sda, n_drv} = 3'b001;
                                n_tick = 8'd0;
                            end
                            PH_SP_A: {n_scl, n_sda, n_drv} = 3'b101;
                            PH_SP_B: {n_scl, n_sda, n_drv} = 3'b111;
                            PH_SP_C: begin
                                {n_scl, n_sda, n_drv} = 3'b111;
                                n_tick = 8'd0;
                            end
                            PH_TX_SET: begin
                                n_scl = 1'b1;
                                n_drv = 1'b1;
                            end
                            PH_TX_HI: begin
                                n_scl = 1'b0;
                                n_drv = 1'b1;
                            end
                            PH_TX_LO: begin
                                n_bit_count = w_bc_inc;
                                n_shift     = {r_shift[6:0], 1'b0};
                                n_scl       = 1'b0;
                                n_drv       = 1'b1;
                                n_tick      = 8'd0;
                                if (!w_bc_inc[3]) begin
                                    n_sda = r_shift[6];
                                end
                            end
                            PH_WA_A: begin
                                {n_scl, n_sda, n_drv} = 3'b110;
                                n_tick = w_short_m1;
                            end
                            PH_RD_LO: begin
                                n_shift = {r_shift[6:0], i_tick.sda_in};
                                {n_scl, n_sda, n_drv} = 3'b110;
                                n_tick = w_short_m1;
                            end
                            PH_RD_HI: begin
                                n_bit_count = w_bc_inc;
                                n_scl       = 1'b0;
                                if (w_bc_inc[3]) begin
                                    n_sda = !r_ack_choice;
                                    n_drv = 1'b1;
                                end else begin
                                    n_sda = 1'b1;
                                    n_drv = 1'b0;
                                end
                            end
                            PH_RD_ACKLO: begin
                                n_scl = 1'b1;
                                n_drv = 1'b1;
                            end
                            PH_RD_ACKHI: begin
                                n_rx   = r_shift;
                                n_scl  = 1'b0;
                                n_drv  = 1'b1;
                                n_tick = 8'd0;
                            end
                            default: begin
                                n_tick = 8'd0;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Result word.
    always_comb begin
        w_word            = '0;
        w_word.scl_level  = n_scl;
        w_word.sda_level  = n_drv ? n_sda : 1'b1;
        w_word.sda_drive  = n_drv;
        w_word.busy_res   = (n_phase != PH_IDLE);
        w_word.done_res   = (r_phase != PH_IDLE) && (n_phase == PH_IDLE);
        w_word.rx_byte    = n_rx;
        w_word.ack_failed = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (w_go) begin
            r_out_word <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= 4'd0;
            r_shift      <= 8'd0;
            r_tick       <= 8'd0;
            r_poll       <= 8'd0;
            r_ack_choice <= 1'b0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_drv        <= 1'b1;
            r_fail       <= 1'b0;
            r_rx         <= 8'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_shift      <= n_shift;
            r_tick       <= n_tick;
            r_poll       <= n_poll;
            r_ack_choice <= n_ack_choice;
            r_scl        <= n_scl;
            r_sda        <= n_sda;
            r_drv        <= n_drv;
            r_fail       <= n_fail;
            r_rx         <= n_rx;
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ hw/rtl/i2c_bit_level_master.sv @@
// ----------------------------------------------------------------------------
// I2C bit-level master
// Path: an accepted tick word waits in the two-entry front queue, then the engine
// registers its result word in the output register, from which the sink takes it.
// Throughput: one tick word per cycle while the queue has room; the engine retires one queued word
// per cycle whenever the output register is free or being emptied.
// Reset: synchronous active-low i_rst_n idles the engine with SCL and SDA
// driven high and loads half_period = 2 and ack_timeout = 250.
// ----------------------------------------------------------------------------
`include "i2c_bit_level_master_defines.svh"

module i2c_bit_level_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  i2cm_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output i2cm_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data
);
    import i2cm_pkg::*;

    t_cfg   r_cfg;
    logic   w_tick_valid;
    t_tick  w_tick;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period <= HALF_PERIOD_RST;
            r_cfg.ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data;
                CFG_ACK_TIMEOUT: r_cfg.ack_timeout <= i_cfg_data;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    i2cm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_pop        (w_pop),
        .o_tick_valid (w_tick_valid),
        .o_tick       (w_tick)
    );

    i2cm_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_tick_valid (w_tick_valid),
        .i_tick       (w_tick),
        .o_tick_pop   (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

    // A full queue can only build up behind a result that is waiting to be taken.
    `I2CM_ASSERT_SAME(a_full_only_when_stalled, i_clk, i_rst_n, !o_in_ready, o_out_valid, "queue full with empty output")

    // A released SDA line always reads as high.
    `I2CM_ASSERT_SAME(a_released_reads_high, i_clk, i_rst_n, o_out_valid && !o_out_word.sda_drive, o_out_word.sda_level, "released SDA not high")

    // A completing word never reports a command still in progress.
    `I2CM_ASSERT_SAME(a_done_not_busy, i_clk, i_rst_n, o_out_valid && o_out_word.done_res, !o_out_word.busy_res, "done while busy")

endmodule

@@ sim/i2c_tick_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit engine result checker
// Watches the tick, result and register channels of the bit engine. Each
// accepted tick word is run through a cycle-free model of the engine's phase
// sequencer, and the expected pin and status word is queued. Every accepted
// result word is compared field by field with the oldest queued word. The
// number of mismatches is handed to the testbench top.
// ----------------------------------------------------------------------------
module i2c_tick_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  i2cm_pkg::t_in_word              i_in_word,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  i2cm_pkg::t_out_word             i_out_word,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [i2cm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data,
    output int                              o_fail_count
);
    import i2cm_pkg::*;

    logic [7:0] hp_reg;
    logic [7:0] to_reg;

    t_phase     ph;
    logic [3:0] nbits;
    logic [7:0] shifter;
    logic [7:0] dwell;
    logic [7:0] polls;
    logic       ack_low;
    logic       scl_q;
    logic       sda_q;
    logic       drv_q;
    logic       timed_out;
    logic [7:0] rx_last;
    logic       done_q;

    t_out_word  engine_status_q[$];
    t_out_word  next_status;
    t_out_word  want;
    int         errors = 0;
    int         n_results = 0;

    assign o_fail_count = errors;

    function automatic logic [7:0] long_len();
        return (hp_reg == 8'd0) ? 8'd1 : hp_reg;
    endfunction

    function automatic logic [7:0] short_len();
        logic [8:0] sum;
        sum = {1'b0, long_len()} + 9'd1;
        return sum[8:1];
    endfunction

    task automatic report(input string msg);
        errors++;
        $display("ERROR [%0t] %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            report($sformatf("result word %0d: %s expected 0x%0h, got 0x%0h",
                             n_results, name, exp_v, got_v));
        end
    endtask

    task automatic enter_phase(input t_phase p, input logic c, input logic d,
                               input logic e, input logic [7:0] n);
        ph = p;
        scl_q = c;
        sda_q = d;
        drv_q = e;
        dwell = n - 8'd1;
    endtask

    task automatic finish_cmd(input logic c, input logic d, input logic e);
        scl_q = c;
        sda_q = d;
        drv_q = e;
        ph = PH_IDLE;
        dwell = 8'd0;
        done_q = 1'b1;
    endtask

    // A low poll is the slave ACK; a high poll past the limit turns into a stop.
    task automatic poll_sda(input logic s);
        if (!s) begin
            finish_cmd(1'b0, 1'b1, 1'b0);
        end else if (polls >= to_reg) begin
            timed_out = 1'b1;
            enter_phase(PH_SP_A, 1'b0, 1'b0, 1'b1, 8'd1);
        end else begin
            polls++;
        end
    endtask

    task automatic advance_engine(input t_in_word w, output t_out_word r);
        done_q = 1'b0;
        if (ph == PH_IDLE) begin
            if (w.cmd_valid) begin
                case (w.opcode)
                    OP_START: enter_phase(PH_ST_A, 1'b1, 1'b1, 1'b1, long_len());
                    OP_STOP:  enter_phase(PH_SP_A, 1'b0, 1'b0, 1'b1, 8'd1);
                    OP_SEND: begin
                        shifter = w.tx_byte;
                        nbits = 4'd0;
                        enter_phase(PH_TX_SET, 1'b0, w.tx_byte[7], 1'b1, 8'd1);
                    end
                    OP_WAIT: begin
                        timed_out = 1'b0;
                        polls = 8'd0;
                        enter_phase(PH_WA_A, scl_q, 1'b1, 1'b0, short_len());
                    end
                    OP_READ: begin
                        ack_low = w.send_ack;
                        shifter = 8'd0;
                        nbits = 4'd0;
                        enter_phase(PH_RD_LO, 1'b0, 1'b1, 1'b0, long_len());
                    end
                    default: ;
                endcase
            end
        end else if (ph == PH_WA_POLL) begin
            poll_sda(w.sda_in);
        end else if (dwell != 8'd0) begin
            dwell--;
        end else begin
            case (ph)
                PH_ST_A:   enter_phase(PH_ST_B, 1'b1, 1'b0, 1'b1, long_len());
                PH_ST_B:   finish_cmd(1'b0, 1'b0, 1'b1);
                PH_SP_A:   enter_phase(PH_SP_B, 1'b1, 1'b0, 1'b1, long_len());
                PH_SP_B:   enter_phase(PH_SP_C, 1'b1, 1'b1, 1'b1, long_len());
                PH_SP_C:   finish_cmd(1'b1, 1'b1, 1'b1);
                PH_TX_SET: enter_phase(PH_TX_HI, 1'b1, sda_q, 1'b1, long_len());
                PH_TX_HI:  enter_phase(PH_TX_LO, 1'b0, sda_q, 1'b1, long_len());
                PH_TX_LO: begin
                    nbits++;
                    shifter = shifter << 1;
                    if (nbits >= 4'd8) begin
                        finish_cmd(1'b0, sda_q, 1'b1);
                    end else begin
                        enter_phase(PH_TX_SET, 1'b0, shifter[7], 1'b1, 8'd1);
                    end
                end
                PH_WA_A:   enter_phase(PH_WA_B, 1'b1, 1'b1, 1'b0, short_len());
                PH_WA_B: begin
                    ph = PH_WA_POLL;
                    dwell = 8'd0;
                    poll_sda(w.sda_in);
                end
                PH_RD_LO: begin
                    shifter = {shifter[6:0], w.sda_in};
                    enter_phase(PH_RD_HI, 1'b1, 1'b1, 1'b0, short_len());
                end
                PH_RD_HI: begin
                    nbits++;
                    if (nbits >= 4'd8) begin
                        enter_phase(PH_RD_ACKLO, 1'b0, !ack_low, 1'b1, long_len());
                    end else begin
                        enter_phase(PH_RD_LO, 1'b0, 1'b1, 1'b0, long_len());
                    end
                end
                PH_RD_ACKLO: enter_phase(PH_RD_ACKHI, 1'b1, sda_q, 1'b1, long_len());
                PH_RD_ACKHI: begin
                    rx_last = shifter;
                    finish_cmd(1'b0, sda_q, 1'b1);
                end
                default: begin
                    ph = PH_IDLE;
                    dwell = 8'd0;
                end
            endcase
        end
        r.scl_level  = scl_q;
        r.sda_level  = drv_q ? sda_q : 1'b1;
        r.sda_drive  = drv_q;
        r.busy_res   = (ph != PH_IDLE);
        r.done_res   = done_q;
        r.rx_byte    = rx_last;
        r.ack_failed = timed_out;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hp_reg = HALF_PERIOD_RST;
            to_reg = ACK_TIMEOUT_RST;
            ph = PH_IDLE;
            nbits = 4'd0;
            shifter = 8'd0;
            dwell = 8'd0;
            polls = 8'd0;
            ack_low = 1'b0;
            scl_q = 1'b1;
            sda_q = 1'b1;
            drv_q = 1'b1;
            timed_out = 1'b0;
            rx_last = 8'd0;
            done_q = 1'b0;
            engine_status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HALF_PERIOD: hp_reg = i_cfg_data;
                    CFG_ACK_TIMEOUT: to_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                advance_engine(i_in_word, next_status);
                engine_status_q.push_back(next_status);
            end
            if (i_out_valid && i_out_ready) begin
                if (engine_status_q.size() == 0) begin
                    report($sformatf("result word %0d arrived with no tick pending",
                                     n_results));
                end else begin
                    want = engine_status_q.pop_front();
                    check_field("scl_level", 8'(want.scl_level),
                                8'(i_out_word.scl_level));
                    check_field("sda_level", 8'(want.sda_level),
                                8'(i_out_word.sda_level));
                    check_field("sda_drive", 8'(want.sda_drive),
                                8'(i_out_word.sda_drive));
                    check_field("busy_res", 8'(want.busy_res),
                                8'(i_out_word.busy_res));
                    check_field("done_res", 8'(want.done_res),
                                8'(i_out_word.done_res));
                    check_field("rx_byte", want.rx_byte, i_out_word.rx_byte);
                    check_field("ack_failed", 8'(want.ack_failed),
                                8'(i_out_word.ack_failed));
                end
                n_results++;
            end
        end
    end

endmodule

@@ sim/tb_i2c_bit_level_master.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit engine testbench
// Drives tick words into the bit engine as command sequences: start, address
// and data bytes, ACK waits, reads with ACK or NACK, and stop. Filler ticks
// carry random SDA levels and sometimes stray commands. A directed pass covers
// byte extremes, ACK timeouts, bad opcodes, commands while busy and extreme
// half periods; random frames then run under several register settings with
// bursty input and a stalling result side. The checker does the comparison.
// ----------------------------------------------------------------------------
module tb_i2c_bit_level_master;
    import i2cm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 4'd9;
    localparam int N_OPCODES  = 8;
    localparam int RAND_TICKS = 600;
    localparam int N_PHASES   = 6;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_word              i_in_word = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [7:0]            i_cfg_data = '0;

    int   fail_count;
    int   n_in = 0;
    int   n_out = 0;
    int   n_done = 0;
    int   n_timeouts = 0;
    int   n_cfg = 0;
    int   burst_left = 0;
    logic last_busy = 1'b0;
    logic last_fail = 1'b0;

    int         stall_mode = 0;
    int         stall_left = 0;
    logic [7:0] stall_mask = 8'hFF;

    logic [7:0] hp_list [N_PHASES] = '{8'd1, 8'd2, 8'd3, 8'd1, 8'd4, 8'd2};
    logic [7:0] to_list [N_PHASES] = '{8'd1, 8'd3, 8'd2, 8'd255, 8'd1, 8'd250};

    i2c_bit_level_master uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    i2c_tick_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_word    (i_in_word),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_word   (o_out_word),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(3);
            stall_left = $urandom_range(16, 160);
            stall_mask = 8'($urandom) | 8'h01;
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(3) != 0);
            2: i_out_ready <= stall_mask[stall_left % 8];
            default: i_out_ready <= ($urandom_range(3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_out <= n_out + 1;
            last_busy <= o_out_word.busy_res;
            last_fail <= o_out_word.ack_failed;
            if (o_out_word.done_res) begin
                n_done <= n_done + 1;
            end
            if (o_out_word.ack_failed && !last_fail) begin
                n_timeouts <= n_timeouts + 1;
            end
        end
    end

    function automatic t_in_word filler(input int noise_pct, input int low_pct);
        t_in_word w;
        w.cmd_valid = ($urandom_range(99) < noise_pct);
        w.opcode    = 3'($urandom_range(N_OPCODES - 1));
        w.tx_byte   = 8'($urandom);
        w.send_ack  = 1'($urandom);
        w.sda_in    = ($urandom_range(99) >= low_pct);
        return w;
    endfunction

    task automatic send_tick(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (!o_in_ready);
        n_in++;
    endtask

    task automatic wait_drain();
        @(negedge i_clk) i_in_valid <= 1'b0;
        while (n_out != n_in) @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drain();
        while (last_busy) begin
            repeat (4) send_tick(filler(0, 50));
            wait_drain();
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic set_config(input logic [7:0] hp, input logic [7:0] to);
        settle();
        repeat (4) @(posedge i_clk);
        cfg_write(CFG_HALF_PERIOD, hp);
        cfg_write(CFG_ACK_TIMEOUT, to);
    endtask

    // Issue one command, then send ticks until it completes (bad op: 3 more).
    task automatic run_cmd(input logic [2:0] op, input logic [7:0] tx, input logic ack,
                           input int low_pct, input int noise_pct);
        int d0;
        int k;
        int bound;
        t_in_word w;
        d0 = n_done;
        bound = (op > OP_READ) ? 3 : 100000;
        w = filler(0, low_pct);
        w.cmd_valid = 1'b1;
        w.opcode = op;
        w.tx_byte = tx;
        w.send_ack = ack;
        send_tick(w);
        k = 0;
        while (n_done == d0 && k < bound) begin
            send_tick(filler(noise_pct, low_pct));
            k++;
        end
    endtask

    task automatic frame(input int noise_pct);
        int n;
        run_cmd(OP_START, 8'($urandom), 1'($urandom), 50, noise_pct);
        run_cmd(OP_SEND, 8'($urandom), 1'($urandom), 50, noise_pct);
        run_cmd(OP_WAIT, 8'($urandom), 1'($urandom), 35, noise_pct);
        n = $urandom_range(1, 3);
        repeat (n) begin
            if ($urandom_range(1) == 0) begin
                run_cmd(OP_SEND, 8'($urandom), 1'($urandom), 50, noise_pct);
                run_cmd(OP_WAIT, 8'($urandom), 1'($urandom), 35, noise_pct);
            end else begin
                run_cmd(OP_READ, 8'($urandom), 1'($urandom), 50, noise_pct);
            end
        end
        run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 50, noise_pct);
    endtask

    initial begin
        int target;
        int pick;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(OP_SEND, 8'hFF, 1'b0, 50, 0);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 50, 0);
        run_cmd(OP_SEND, 8'h00, 1'b1, 50, 0);
        run_cmd(OP_WAIT, 8'hFF, 1'b1, 0, 0);
        run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(OP_READ, 8'h00, 1'b1, 50, 0);
        run_cmd(OP_READ, 8'hFF, 1'b0, 50, 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50, 0);
        for (int op = int'(OP_READ) + 1; op < N_OPCODES; op++) begin
            run_cmd(3'(op), 8'($urandom), 1'($urandom), 50, 0);
        end
        run_cmd(OP_START, 8'h00, 1'b0, 50, 60);
        settle();

        set_config(8'd0, 8'd1);
        cfg_write(CFG_UNUSED, 8'h5A);
        run_cmd(OP_START, 8'h00, 1'b0, 50, 0);
        run_cmd(OP_SEND, 8'h81, 1'b0, 50, 0);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 0, 0);
        run_cmd(OP_READ, 8'h00, 1'b1, 50, 0);
        run_cmd(OP_STOP, 8'h00, 1'b0, 50, 0);

        set_config(8'd255, 8'd1);
        run_cmd(OP_WAIT, 8'h00, 1'b0, 100, 0);

        for (int p = 0; p < N_PHASES; p++) begin
            set_config(hp_list[p], to_list[p]);
            target = n_in + RAND_TICKS / N_PHASES;
            while (n_in < target) begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    wait_drain();
                end
                if (pick < 75) begin
                    frame(($urandom_range(3) == 0) ? 10 : 0);
                end else if (pick < 90) begin
                    run_cmd(3'($urandom_range(N_OPCODES - 1)), 8'($urandom),
                            1'($urandom), 40, 15);
                end else begin
                    run_cmd(OP_READ, 8'($urandom), 1'($urandom), 50, 0);
                    run_cmd(OP_START, 8'($urandom), 1'($urandom), 50, 0);
                    run_cmd(OP_STOP, 8'($urandom), 1'($urandom), 50, 0);
                end
            end
        end

        wait_drain();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d tick words, %0d completed commands, %0d ACK timeouts,",
                 n_in, n_done, n_timeouts);
        $display("and %0d register writes; %0d mismatches found.", n_cfg, fail_count);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Run did not finish in the allowed time.");
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ i2c_bit_level_master.f @@
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_engine.sv
hw/rtl/i2c_bit_level_master.sv
sim/i2c_tick_checker.sv
sim/tb_i2c_bit_level_master.sv
